/* sv/itoa_pkg.sv */
// Package for the integer to ASCII radix converter.
// Holds shared widths, radix limits, the reciprocal table and the digit encoder.
// No dependencies.
package itoa_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned RadixW = 6;
  localparam int unsigned CharW  = 7;
  localparam int unsigned DigitW = 6;
  localparam int unsigned MaxDigits = 32;
  localparam int unsigned CountW = $clog2(MaxDigits);

  localparam logic [RadixW-1:0] RadixMin   = RadixW'(2);
  localparam logic [RadixW-1:0] RadixMax   = RadixW'(36);
  localparam logic [RadixW-1:0] RadixReset = RadixW'(10);
  localparam logic [RadixW-1:0] RadixDec   = RadixW'(10);

  localparam logic [CharW-1:0] CharMinus = CharW'(8'h2D);
  localparam logic [CharW-1:0] CharZero  = CharW'(8'h30);
  localparam logic [CharW-1:0] CharUpA   = CharW'(8'h41);

  // floor(2^32 / radix); the estimate it gives is at most one below the quotient
  function automatic logic [ValueW-1:0] itoa_recip(input logic [RadixW-1:0] b);
    logic [ValueW-1:0] r;
    case (b)
      6'd2:    r = 32'h8000_0000;
      6'd3:    r = 32'h5555_5555;
      6'd4:    r = 32'h4000_0000;
      6'd5:    r = 32'h3333_3333;
      6'd6:    r = 32'h2AAA_AAAA;
      6'd7:    r = 32'h2492_4924;
      6'd8:    r = 32'h2000_0000;
      6'd9:    r = 32'h1C71_C71C;
      6'd10:   r = 32'h1999_9999;
      6'd11:   r = 32'h1745_D174;
      6'd12:   r = 32'h1555_5555;
      6'd13:   r = 32'h13B1_3B13;
      6'd14:   r = 32'h1249_2492;
      6'd15:   r = 32'h1111_1111;
      6'd16:   r = 32'h1000_0000;
      6'd17:   r = 32'h0F0F_0F0F;
      6'd18:   r = 32'h0E38_E38E;
      6'd19:   r = 32'h0D79_435E;
      6'd20:   r = 32'h0CCC_CCCC;
      6'd21:   r = 32'h0C30_C30C;
      6'd22:   r = 32'h0BA2_E8BA;
      6'd23:   r = 32'h0B21_642C;
      6'd24:   r = 32'h0AAA_AAAA;
      6'd25:   r = 32'h0A3D_70A3;
      6'd26:   r = 32'h09D8_9D89;
      6'd27:   r = 32'h097B_425E;
      6'd28:   r = 32'h0924_9249;
      6'd29:   r = 32'h08D3_DCB0;
      6'd30:   r = 32'h0888_8888;
      6'd31:   r = 32'h0842_1084;
      6'd32:   r = 32'h0800_0000;
      6'd33:   r = 32'h07C1_F07C;
      6'd34:   r = 32'h0787_8787;
      6'd35:   r = 32'h0750_7507;
      6'd36:   r = 32'h071C_71C7;
      default: r = 32'h8000_0000;
    endcase
    return r;
  endfunction

  // digit value to ASCII: '0'-'9' then 'A'-'Z'
  function automatic logic [CharW-1:0] itoa_char(input logic [DigitW-1:0] d);
    logic [CharW-1:0] c;
    if (d < DigitW'(10)) begin
      c = CharZero + CharW'(d);
    end else begin
      c = CharUpA + CharW'(d - DigitW'(10));
    end
    return c;
  endfunction

endpackage

/* sv/integer_to_ascii_radix.sv */
// Each digit takes a multiply step (S_MUL) then a correct step (S_DIV) of divide, with
// N <= 32 digits (at most 10 in radix 10); then the sign (radix 10, negative) and the
// N characters leave one a cycle while out_stall is low. A new value is not taken until
// the last character is loaded; throughput is set by the shared reciprocal multiplier
// and the digit buffer.
// Reset (rst_n low, synchronous): sequencer idle, output empty, radix back to 10.
// Top level of the integer to ASCII converter; depends on itoa_pkg.
module integer_to_ascii_radix
  import itoa_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [RadixW-1:0]      cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic signed [ValueW-1:0] in_value,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [CharW-1:0]       out_character,
  output logic                   out_last
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_SIGN,
    S_EMIT
  } state_t;

  state_t                state_r;
  logic [RadixW-1:0]     radix_r;
  logic [ValueW-1:0]     mag_r;
  logic [ValueW-1:0]     qest_r;
  logic                  neg_r;
  logic [CountW-1:0]     ndig_r;
  logic [CountW-1:0]     idx_r;
  logic [DigitW-1:0]     dbuf_r [MaxDigits];
  logic                  out_valid_r;
  logic [CharW-1:0]      out_char_r;
  logic                  out_last_r;

  logic                  in_acc;
  logic                  out_free;
  logic                  out_load;
  logic [2*ValueW-1:0]   prod;
  logic [ValueW+RadixW-1:0] qr_full;
  logic [CharW:0]        rem_est;
  logic                  fix;
  logic [ValueW-1:0]     quot;
  logic [DigitW-1:0]     digit;

  assign in_stall      = (state_r != S_IDLE);
  assign in_acc        = in_valid && !in_stall;
  assign out_free      = !out_valid_r || !out_stall;
  assign out_load      = out_free && ((state_r == S_SIGN) || (state_r == S_EMIT));
  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;

  // shared divide unit: reciprocal multiply, then back-multiply and one correction
  always_comb begin
    prod    = 64'(mag_r) * 64'(itoa_recip(radix_r));
    qr_full = (ValueW + RadixW)'(qest_r) * (ValueW + RadixW)'(radix_r);
    rem_est = (CharW + 1)'(mag_r - qr_full[ValueW-1:0]);
    fix     = (rem_est >= (CharW + 1)'(radix_r));
    quot    = fix ? (qest_r + ValueW'(1)) : qest_r;
    digit   = fix ? DigitW'(rem_est - (CharW + 1)'(radix_r)) : DigitW'(rem_est);
  end

  // digit buffer, filled least significant digit first
  always_ff @(posedge clk) begin
    if (state_r == S_DIV) begin
      dbuf_r[ndig_r] <= digit;
    end
  end

  // sequencer, radix register and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      radix_r     <= RadixReset;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_wdata < RadixMin) begin
          radix_r <= RadixMin;
        end else if (cfg_wdata > RadixMax) begin
          radix_r <= RadixMax;
        end else begin
          radix_r <= cfg_wdata;
        end
      end

      // output empties unless a new character is loaded this cycle
      if (out_valid_r && !out_stall && !out_load) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            neg_r   <= (radix_r == RadixDec) && in_value[ValueW-1];
            mag_r   <= ((radix_r == RadixDec) && in_value[ValueW-1]) ?
                       (ValueW'(0) - ValueW'(in_value)) : ValueW'(in_value);
            ndig_r  <= '0;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          qest_r  <= prod[2*ValueW-1:ValueW];
          state_r <= S_DIV;
        end
        S_DIV: begin
          mag_r  <= quot;
          ndig_r <= ndig_r + CountW'(1);
          if ((quot == '0) || (ndig_r == CountW'(MaxDigits - 1))) begin
            idx_r   <= ndig_r;
            state_r <= neg_r ? S_SIGN : S_EMIT;
          end else begin
            state_r <= S_MUL;
          end
        end
        S_SIGN: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_char_r  <= CharMinus;
            out_last_r  <= 1'b0;
            state_r     <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_char_r  <= itoa_char(dbuf_r[idx_r]);
            out_last_r  <= (idx_r == '0);
            if (idx_r == '0) begin
              state_r <= S_IDLE;
            end else begin
              idx_r <= idx_r - CountW'(1);
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

/* sv/itoa_chk.sv */
// Port-level checker for the integer to ASCII converter, bound to the top level.
// Depends on itoa_pkg and integer_to_ascii_radix.
module itoa_chk
  import itoa_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic [CharW-1:0]         out_character,
  input logic                     out_last
);

  // stalled transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_character) && $stable(out_last))
    else $error("output transaction changed while stalled");

  // only sign, digits and upper-case letters
  a_out_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_character == CharMinus) ||
                  ((out_character >= CharZero) && (out_character <= CharW'(8'h39))) ||
                  ((out_character >= CharUpA) && (out_character <= CharW'(8'h5A))))
    else $error("character outside the digit set");

  // sign is never the final character
  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_character == CharMinus) |-> !out_last)
    else $error("minus sign flagged as last");

  // busy once a value is taken
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("converter took a value without going busy");

  // reset empties the output
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind integer_to_ascii_radix itoa_chk u_itoa_chk (.*);
